FILE: hdl/mss_pkg.sv
// shared types, constants and helper functions for the motor stall supervisor
// no dependencies; used by mss_step, mss_ramp and motor_stall_supervisor_top
package mss_pkg;

  localparam int unsigned SIDES = 2;

  // linear ramp length in milliseconds and the reciprocal used to divide by it
  localparam int unsigned RAMP_MS      = 150;
  localparam int unsigned RAMP_EL_W    = $clog2(RAMP_MS + 1);
  localparam int unsigned RAMP_PROD_W  = 16 + RAMP_EL_W;
  localparam int unsigned RAMP_SHIFT   = RAMP_PROD_W + RAMP_EL_W;
  localparam int unsigned RAMP_RECIP_W = RAMP_SHIFT - RAMP_EL_W + 2;
  localparam int unsigned RAMP_QUOT_W  = RAMP_PROD_W + RAMP_RECIP_W;
  localparam logic [63:0] RAMP_RECIP   =
    ((64'd1 << RAMP_SHIFT) + 64'(RAMP_MS) - 64'd1) / 64'(RAMP_MS);

  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [14:0] CMD_FLOOR_RST       = 15'd300;
  localparam logic [15:0] DETECT_MS_RST       = 16'd120;
  localparam logic [15:0] CMD_TRIGGER_RST     = 16'd350;
  localparam logic [15:0] SPEED_TRIGGER_RST   = 16'd40;
  localparam logic [15:0] CURRENT_TRIGGER_RST = 16'd350;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CMD_FLOOR       = 3'd0,
    CFG_DETECT_MS       = 3'd1,
    CFG_CMD_TRIGGER     = 3'd2,
    CFG_SPEED_TRIGGER   = 3'd3,
    CFG_CURRENT_TRIGGER = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_RAMP   = 2'd1,
    MODE_HOLD   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [14:0] cmd_floor;
    logic [15:0] detect_ms;
    logic [15:0] cmd_trigger;
    logic [15:0] speed_trigger;
    logic [15:0] current_trigger;
  } cfg_t;

  // one update; side 0 is left, side 1 is right
  typedef struct packed {
    logic [31:0]            time_now_ms;
    logic [SIDES-1:0][15:0] request;
    logic [SIDES-1:0][15:0] speed;
    logic [SIDES-1:0][15:0] current;
  } upd_t;

  // after the state update: either a final drive value or ramp operands
  typedef struct packed {
    logic                   active;
    logic                   ramp;
    logic [SIDES-1:0][15:0] drv;
    logic [SIDES-1:0][15:0] from;
    logic [SIDES-1:0]       neg;
    logic [SIDES-1:0][15:0] span_mag;
    logic [RAMP_EL_W-1:0]   elapsed;
  } step_t;

  typedef struct packed {
    logic                   active;
    logic [SIDES-1:0][15:0] drive;
  } res_t;

  // magnitude of a signed 16 bit value, 32768 for the most negative code
  function automatic logic [16:0] mag17(input logic [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (~ext + 17'd1) : ext;
  endfunction

  // clamp a signed request to +-floor_v
  function automatic logic [15:0] clamp_floor(input logic [15:0] r,
                                              input logic [14:0] floor_v);
    logic signed [16:0] r_ext;
    logic signed [16:0] f_ext;
    logic signed [16:0] nf_ext;
    r_ext  = signed'({r[15], r});
    f_ext  = signed'({2'b00, floor_v});
    nf_ext = -f_ext;
    if (r_ext > f_ext) begin
      return {1'b0, floor_v};
    end else if (r_ext < nf_ext) begin
      return nf_ext[15:0];
    end else begin
      return r;
    end
  endfunction

endpackage

FILE: hdl/mss_step.sv
// stall detection and mode sequencing, with its result stage; one update per cycle
// while the result stage is not stalled; depends on mss_pkg
module mss_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mss_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  input  mss_pkg::upd_t   in_upd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output mss_pkg::step_t  out_step_o,
  input  logic            out_ready_i
);
  import mss_pkg::*;

  mode_e                  mode_d, mode_q;
  logic [31:0]            entered_d, entered_q;
  logic [31:0]            detect_d, detect_q;
  logic [SIDES-1:0][15:0] from_d, from_q;
  logic [SIDES-1:0][15:0] to_d, to_q;
  logic [SIDES-1:0][16:0] span;
  logic [31:0]            now;
  logic [31:0]            elapsed;
  logic                   slow, hi_cur, hi_req, stall;
  logic                   advance;
  logic                   valid_q;
  step_t                  step_d, step_q;

  assign now = in_upd_i.time_now_ms;

  assign slow   = (mag17(in_upd_i.speed[0]) <= {1'b0, cfg_i.speed_trigger})
               || (mag17(in_upd_i.speed[1]) <= {1'b0, cfg_i.speed_trigger});
  assign hi_cur = (mag17(in_upd_i.current[0]) >= {1'b0, cfg_i.current_trigger})
               || (mag17(in_upd_i.current[1]) >= {1'b0, cfg_i.current_trigger});
  assign hi_req = (mag17(in_upd_i.request[0]) >= {1'b0, cfg_i.cmd_trigger})
               || (mag17(in_upd_i.request[1]) >= {1'b0, cfg_i.cmd_trigger});
  assign stall  = slow && (hi_cur || hi_req);

  assign in_ready_o = !valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;
  assign elapsed    = now - entered_q;

  always_comb begin
    mode_d    = mode_q;
    entered_d = entered_q;
    detect_d  = detect_q;
    from_d    = from_q;
    to_d      = to_q;

    step_d.ramp    = 1'b0;
    step_d.drv     = in_upd_i.request;
    step_d.from    = from_q;
    step_d.elapsed = elapsed[RAMP_EL_W-1:0];
    for (int s = 0; s < SIDES; s++) begin
      span[s]            = {from_q[s][15], from_q[s]} - {to_q[s][15], to_q[s]};
      step_d.neg[s]      = span[s][16];
      step_d.span_mag[s] = span[s][16] ? 16'(~span[s] + 17'd1) : span[s][15:0];
    end

    unique case (mode_q)
      MODE_NORMAL: begin
        if (stall) begin
          if (detect_q == 32'd0) begin
            detect_d = now;
          end else if ((now - detect_q) >= {16'd0, cfg_i.detect_ms}) begin
            mode_d    = MODE_RAMP;
            entered_d = now;
            from_d    = in_upd_i.request;
            for (int s = 0; s < SIDES; s++) begin
              to_d[s] = clamp_floor(in_upd_i.request[s], cfg_i.cmd_floor);
            end
          end
        end else begin
          detect_d = 32'd0;
        end
      end
      MODE_RAMP: begin
        if (elapsed < 32'(RAMP_MS)) begin
          step_d.ramp = 1'b1;
        end else begin
          step_d.drv = to_q;
          mode_d     = MODE_HOLD;
          entered_d  = now;
        end
      end
      MODE_HOLD: begin
        if (stall) begin
          for (int s = 0; s < SIDES; s++) begin
            step_d.drv[s] = clamp_floor(in_upd_i.request[s], cfg_i.cmd_floor);
          end
        end else begin
          mode_d    = MODE_NORMAL;
          entered_d = now;
          detect_d  = 32'd0;
        end
      end
      default: begin
        mode_d    = MODE_NORMAL;
        entered_d = now;
        detect_d  = 32'd0;
      end
    endcase

    step_d.active = (mode_d != MODE_NORMAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      mode_q    <= MODE_NORMAL;
      entered_q <= 32'd0;
      detect_q  <= 32'd0;
      from_q    <= '0;
      to_q      <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (advance) begin
        mode_q    <= mode_d;
        entered_q <= entered_d;
        detect_q  <= detect_d;
        from_q    <= from_d;
        to_q      <= to_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      step_q <= step_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_step_o  = step_q;

endmodule

FILE: hdl/mss_ramp.sv
// ramp interpolation: span times elapsed, reciprocal divide, final drive select
// three register stages with per-stage stall; depends on mss_pkg
module mss_ramp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mss_pkg::step_t  in_step_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output mss_pkg::res_t   out_res_o,
  input  logic            out_ready_i
);
  import mss_pkg::*;

  typedef struct packed {
    logic                   active;
    logic                   ramp;
    logic [SIDES-1:0][15:0] drv;
    logic [SIDES-1:0][15:0] from;
    logic [SIDES-1:0]       neg;
  } carry_t;

  localparam logic [RAMP_RECIP_W-1:0] RECIP = RAMP_RECIP[RAMP_RECIP_W-1:0];

  logic                            mul_v_q, div_v_q, out_v_q;
  logic                            mul_ready, div_ready, out_ready;
  carry_t                          in_carry, mul_carry_q, div_carry_q;
  logic [SIDES-1:0][RAMP_PROD_W-1:0] prod_d, prod_q;
  logic [SIDES-1:0][RAMP_QUOT_W-1:0] quot_full;
  logic [SIDES-1:0][15:0]          quot_d, quot_q;
  logic [SIDES-1:0][16:0]          sum;
  res_t                            res_d, res_q;

  assign out_ready  = !out_v_q || out_ready_i;
  assign div_ready  = !div_v_q || out_ready;
  assign mul_ready  = !mul_v_q || div_ready;
  assign in_ready_o = mul_ready;

  assign in_carry.active = in_step_i.active;
  assign in_carry.ramp   = in_step_i.ramp;
  assign in_carry.drv    = in_step_i.drv;
  assign in_carry.from   = in_step_i.from;
  assign in_carry.neg    = in_step_i.neg;

  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      prod_d[s]    = RAMP_PROD_W'(in_step_i.span_mag[s]) *
                     RAMP_PROD_W'(in_step_i.elapsed);
      quot_full[s] = RAMP_QUOT_W'(prod_q[s]) * RAMP_QUOT_W'(RECIP);
      quot_d[s]    = quot_full[s][RAMP_SHIFT +: 16];
      // quotient never exceeds the span, so the result stays between start and target
      sum[s]       = div_carry_q.neg[s]
                   ? ({div_carry_q.from[s][15], div_carry_q.from[s]} + {1'b0, quot_q[s]})
                   : ({div_carry_q.from[s][15], div_carry_q.from[s]} - {1'b0, quot_q[s]});
      res_d.drive[s] = div_carry_q.ramp ? sum[s][15:0] : div_carry_q.drv[s];
    end
    res_d.active = div_carry_q.active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      div_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_v_q <= in_valid_i;
      end
      if (div_ready) begin
        div_v_q <= mul_v_q;
      end
      if (out_ready) begin
        out_v_q <= div_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      mul_carry_q <= in_carry;
      prod_q      <= prod_d;
    end
    if (div_ready && mul_v_q) begin
      div_carry_q <= mul_carry_q;
      quot_q      <= quot_d;
    end
    if (out_ready && div_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = res_q;

endmodule

FILE: hdl/motor_stall_supervisor_top.sv
// top level of the motor stall supervisor: ports, config registers, input register
// depends on mss_pkg, mss_step and mss_ramp
//
// Usage:
//   s_axis carries one update per request: timestamp, left/right drive requests,
//   wheel speeds and currents. m_axis returns exactly one result per update, in
//   order: supervised left/right drive, drive enable (always 1) and the active
//   flag (ramp or hold after that update).
//   cfg_we_i/cfg_idx_i/cfg_data_i write one threshold register per cycle; write
//   only while no update is in flight. Indexes above the last register are ignored.
//   Path: a result passes the input register, mode step, ramp multiply, reciprocal
//   divide and output register, in that order.
//   Throughput: one update per cycle while no stage is stalled; the mode state is
//   updated once per update so consecutive updates follow without gaps.
//   Reset: mode normal, timers cleared, registers at their defaults, pipeline empty.
//   When m_axis_tready is low, each stage holds; empty stages keep filling, so
//   s_axis_tready drops only once every stage is occupied.
module motor_stall_supervisor_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // time_now_ms[31:0], request_left[47:32], request_right[63:48], speed_left[79:64],
  // speed_right[95:80], current_left[111:96], current_right[127:112]
  input  logic [mss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // drive_left[15:0], drive_right[31:16], drive_enable[32], supervisor_active[33],
  // zero fill [39:34]
  output logic [mss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import mss_pkg::*;

  cfg_t                    cfg_q;
  logic                    in_v_q;
  logic [IN_TDATA_W-1:0]   in_data_q;
  upd_t                    upd;
  logic                    step_ready;
  logic                    step_valid;
  step_t                   step_bus;
  logic                    ramp_ready;
  res_t                    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_floor       <= CMD_FLOOR_RST;
      cfg_q.detect_ms       <= DETECT_MS_RST;
      cfg_q.cmd_trigger     <= CMD_TRIGGER_RST;
      cfg_q.speed_trigger   <= SPEED_TRIGGER_RST;
      cfg_q.current_trigger <= CURRENT_TRIGGER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CMD_FLOOR:       cfg_q.cmd_floor       <= cfg_data_i[14:0];
        CFG_DETECT_MS:       cfg_q.detect_ms       <= cfg_data_i;
        CFG_CMD_TRIGGER:     cfg_q.cmd_trigger     <= cfg_data_i;
        CFG_SPEED_TRIGGER:   cfg_q.speed_trigger   <= cfg_data_i;
        CFG_CURRENT_TRIGGER: cfg_q.current_trigger <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  assign s_axis_tready = !in_v_q || step_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  assign upd.time_now_ms = in_data_q[31:0];
  assign upd.request[0]  = in_data_q[47:32];
  assign upd.request[1]  = in_data_q[63:48];
  assign upd.speed[0]    = in_data_q[79:64];
  assign upd.speed[1]    = in_data_q[95:80];
  assign upd.current[0]  = in_data_q[111:96];
  assign upd.current[1]  = in_data_q[127:112];

  mss_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_v_q),
    .in_upd_i    (upd),
    .in_ready_o  (step_ready),
    .out_valid_o (step_valid),
    .out_step_o  (step_bus),
    .out_ready_i (ramp_ready)
  );

  mss_ramp u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (step_valid),
    .in_step_i   (step_bus),
    .in_ready_o  (ramp_ready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res.active, 1'b1, res.drive[1], res.drive[0]};

  // a stalled input register keeps its update
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !step_ready |=> in_v_q && $stable(in_data_q))
    else $error("input register lost or changed a waiting update");

  // ramp output only happens while the supervisor is active
  a_ramp_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid && step_bus.ramp |-> step_bus.active)
    else $error("ramp result flagged while supervisor inactive");

  // mode step result holds while the ramp pipeline is full
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid && !ramp_ready |=> step_valid && $stable(step_bus))
    else $error("mode step result changed while stalled");

endmodule

FILE: dv/motor_stall_supervisor_top_test.sv
// testbench for motor_stall_supervisor_top: directed and random updates against a
// built-in stall supervisor predictor, random stalls on both stream sides
// depends on mss_pkg and motor_stall_supervisor_top
module motor_stall_supervisor_top_test;
  import mss_pkg::*;

  localparam int RAMP_LEN = RAMP_MS;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [15:0] req_l;
    logic signed [15:0] req_r;
    logic signed [15:0] spd_l;
    logic signed [15:0] spd_r;
    logic signed [15:0] cur_l;
    logic signed [15:0] cur_r;
  } update_t;

  typedef struct packed {
    logic signed [15:0] drv_l;
    logic signed [15:0] drv_r;
    logic               enable;
    logic               active;
  } drive_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  motor_stall_supervisor_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the threshold registers
  logic [14:0] floor_q  = CMD_FLOOR_RST;
  logic [15:0] detect_q = DETECT_MS_RST;
  logic [15:0] ctrig_q  = CMD_TRIGGER_RST;
  logic [15:0] strig_q  = SPEED_TRIGGER_RST;
  logic [15:0] itrig_q  = CURRENT_TRIGGER_RST;

  // supervisor state as predicted
  mode_e              sup_mode     = MODE_NORMAL;
  logic [31:0]        mode_since   = '0;
  logic [31:0]        detect_since = '0;
  logic signed [15:0] ramp_start_l = '0;
  logic signed [15:0] ramp_start_r = '0;
  logic signed [15:0] ramp_goal_l  = '0;
  logic signed [15:0] ramp_goal_r  = '0;

  drive_t      expected_drive[$];
  int unsigned sent_count  = 0;
  int unsigned error_count = 0;
  logic [31:0] clock_ms    = '0;
  bit          src_calm    = 1'b0;

  function automatic int magnitude(logic signed [15:0] v);
    int x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [15:0] floor_clamp(logic signed [15:0] v);
    int f;
    int x;
    f = int'(floor_q);
    x = v;
    if (x > f) return 16'(f);
    if (x < -f) return 16'(-f);
    return v;
  endfunction

  function automatic logic signed [15:0] ramp_point(logic signed [15:0] start,
                                                    logic signed [15:0] goal,
                                                    logic [31:0] el);
    int span;
    int step;
    span = int'(start) - int'(goal);
    step = (span * int'(el)) / RAMP_LEN;
    return 16'(int'(start) - step);
  endfunction

  function automatic drive_t next_drive(update_t u);
    drive_t      d;
    logic        slow;
    logic        hi_cur;
    logic        hi_req;
    logic        stalled;
    logic [31:0] el;
    d.drv_l  = u.req_l;
    d.drv_r  = u.req_r;
    d.enable = 1'b1;
    slow    = magnitude(u.spd_l) <= int'(strig_q) || magnitude(u.spd_r) <= int'(strig_q);
    hi_cur  = magnitude(u.cur_l) >= int'(itrig_q) || magnitude(u.cur_r) >= int'(itrig_q);
    hi_req  = magnitude(u.req_l) >= int'(ctrig_q) || magnitude(u.req_r) >= int'(ctrig_q);
    stalled = slow && (hi_cur || hi_req);
    case (sup_mode)
      MODE_NORMAL: begin
        if (stalled) begin
          el = u.stamp - detect_since;
          // a timer armed at time zero still reads as disarmed
          if (detect_since == '0) begin
            detect_since = u.stamp;
          end else if (el >= 32'(detect_q)) begin
            sup_mode     = MODE_RAMP;
            mode_since   = u.stamp;
            ramp_start_l = u.req_l;
            ramp_start_r = u.req_r;
            ramp_goal_l  = floor_clamp(u.req_l);
            ramp_goal_r  = floor_clamp(u.req_r);
          end
        end else begin
          detect_since = '0;
        end
      end
      MODE_RAMP: begin
        el = u.stamp - mode_since;
        if (el < 32'(RAMP_LEN)) begin
          d.drv_l = ramp_point(ramp_start_l, ramp_goal_l, el);
          d.drv_r = ramp_point(ramp_start_r, ramp_goal_r, el);
        end else begin
          d.drv_l    = ramp_goal_l;
          d.drv_r    = ramp_goal_r;
          sup_mode   = MODE_HOLD;
          mode_since = u.stamp;
        end
      end
      MODE_HOLD: begin
        if (stalled) begin
          d.drv_l = floor_clamp(u.req_l);
          d.drv_r = floor_clamp(u.req_r);
        end else begin
          sup_mode     = MODE_NORMAL;
          mode_since   = u.stamp;
          detect_since = '0;
        end
      end
      default: begin
        sup_mode     = MODE_NORMAL;
        mode_since   = u.stamp;
        detect_since = '0;
      end
    endcase
    d.active = (sup_mode != MODE_NORMAL);
    return d;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // signed value of magnitude m, random sign; 32768 maps to the most negative code
  function automatic logic signed [15:0] signed_of_mag(int unsigned m);
    if (m >= 32768) return 16'sh8000;
    return ($urandom_range(0, 1) != 0) ? -16'(m) : 16'(m);
  endfunction

  function automatic logic signed [15:0] pick_in(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return signed_of_mag(lo);
    if (r == 1) return signed_of_mag(hi);
    return signed_of_mag($urandom_range(lo, hi));
  endfunction

  function automatic update_t update_of(logic [31:0] stamp, int rl, int rr, int sl, int sr,
                                        int cl, int cr);
    update_t u;
    u.stamp = stamp;
    u.req_l = 16'(rl);
    u.req_r = 16'(rr);
    u.spd_l = 16'(sl);
    u.spd_r = 16'(sr);
    u.cur_l = 16'(cl);
    u.cur_r = 16'(cr);
    return u;
  endfunction

  function automatic update_t noise_update();
    return update_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // update that is built to stall or not under the current thresholds, where possible
  function automatic update_t shaped_update(logic [31:0] stamp, bit stalled);
    update_t     u;
    int unsigned lim;
    u = noise_update();
    u.stamp = stamp;
    if (stalled) begin
      lim = (strig_q > 32768) ? 32768 : strig_q;
      if ($urandom_range(0, 1) != 0) u.spd_l = pick_in(0, lim);
      else u.spd_r = pick_in(0, lim);
      case ($urandom_range(0, 3))
        0: if (itrig_q <= 32768) u.cur_l = pick_in(itrig_q, 32768);
        1: if (itrig_q <= 32768) u.cur_r = pick_in(itrig_q, 32768);
        2: if (ctrig_q <= 32768) u.req_l = pick_in(ctrig_q, 32768);
        default: if (ctrig_q <= 32768) u.req_r = pick_in(ctrig_q, 32768);
      endcase
      if ($urandom_range(0, 3) == 0) u.req_l = pick_in(0, 2 * floor_q + 1);
    end else if (strig_q < 32768 && ($urandom_range(0, 2) != 0 || itrig_q == 0 ||
                                     ctrig_q == 0)) begin
      u.spd_l = pick_in(strig_q + 1, 32768);
      u.spd_r = pick_in(strig_q + 1, 32768);
    end else if (itrig_q != 0 && ctrig_q != 0) begin
      lim = (itrig_q > 32769) ? 32768 : itrig_q - 1;
      u.cur_l = pick_in(0, lim);
      u.cur_r = pick_in(0, lim);
      lim = (ctrig_q > 32769) ? 32768 : ctrig_q - 1;
      u.req_l = pick_in(0, lim);
      u.req_r = pick_in(0, lim);
    end
    return u;
  endfunction

  function automatic logic [31:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return $urandom_range(1, 40);
    if (r < 90) return $urandom_range(100, 400);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_threshold(int unsigned typical_hi);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, typical_hi));
    endcase
  endfunction

  task automatic send_update(update_t u);
    int unsigned gap;
    s_axis_tdata  <= {u.cur_r, u.cur_l, u.spd_r, u.spd_l, u.req_r, u.req_l, u.stamp};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_drive.push_back(next_drive(u));
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CMD_FLOOR:       floor_q  = data[14:0];
      CFG_DETECT_MS:       detect_q = data;
      CFG_CMD_TRIGGER:     ctrig_q  = data;
      CFG_SPEED_TRIGGER:   strig_q  = data;
      CFG_CURRENT_TRIGGER: itrig_q  = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [14:0] fl, logic [15:0] det, logic [15:0] ct,
                            logic [15:0] st, logic [15:0] it);
    settle();
    write_reg(CFG_CMD_FLOOR, {1'($urandom), fl});
    write_reg(CFG_DETECT_MS, det);
    write_reg(CFG_CMD_TRIGGER, ct);
    write_reg(CFG_SPEED_TRIGGER, st);
    write_reg(CFG_CURRENT_TRIGGER, it);
    // index past the last register must leave everything alone
    write_reg(3'(CFG_CURRENT_TRIGGER) + 3'($urandom_range(1, 3)), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic stall_episode();
    int unsigned n_stall;
    int unsigned n_clear;
    n_stall = $urandom_range(1, 24);
    n_clear = $urandom_range(1, 4);
    repeat (n_stall) begin
      clock_ms += pick_step();
      send_update(shaped_update(clock_ms, $urandom_range(0, 19) != 0));
    end
    repeat (n_clear) begin
      clock_ms += pick_step();
      send_update(shaped_update(clock_ms, 1'b0));
    end
  endtask

  task automatic test_passthrough_extremes();
    send_update(update_of(32'h0, 0, 0, 0, 0, 0, 0));
    send_update(update_of(32'hFFFF_FFFF, 32767, -32768, 32767, -32768, -32768, 32767));
    send_update(update_of(32'h1, -32768, 32767, -32768, 32767, 0, 0));
    // request and current just below their triggers, speeds at and just past theirs
    send_update(update_of(32'h2, 349, -349, 40, -41, 349, -349));
  endtask

  task automatic test_detect_armed_at_zero();
    // armed at time zero reads as disarmed, so it re-arms at 100
    send_update(update_of(32'd0, 1000, -1000, 0, 500, 350, 0));
    send_update(update_of(32'd100, 1000, -1000, 0, 500, 350, 0));
    send_update(update_of(32'd219, 1000, -1000, -40, 500, 0, -350));
    send_update(update_of(32'd230, 1000, -1000, 500, 500, 350, 0));
  endtask

  task automatic test_ramp_hold_release();
    send_update(update_of(32'd1000, 20000, -7, 3, 900, 0, 0));
    send_update(update_of(32'd1120, 20000, -7, 3, 900, 0, 0));
    send_update(update_of(32'd1195, 1, 1, 9000, 9000, 0, 0));
    send_update(update_of(32'd1269, 1, 1, 9000, 9000, 0, 0));
    send_update(update_of(32'd1270, 1, 1, 9000, 9000, 0, 0));
    send_update(update_of(32'd1280, -5000, 200, 0, 0, 0, 0));
    send_update(update_of(32'd1290, -5000, 200, 800, 800, 0, 0));
  endtask

  task automatic test_stamp_wrap();
    send_update(update_of(32'hFFFF_FF00, -32768, 32767, 0, 0, 0, 0));
    send_update(update_of(32'hFFFF_FF78, -32768, 32767, 0, 0, 0, 0));
    send_update(update_of(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0));
    send_update(update_of(32'h0000_0004, 0, 0, 0, 0, 0, 0));
    send_update(update_of(32'h0000_000E, 0, 0, 0, 0, 0, 0));
    send_update(update_of(32'h0000_0020, 0, 0, 9000, 9000, 0, 0));
  endtask

  task automatic test_config_extremes();
    set_config(15'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (3) stall_episode();
    set_config(15'd32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) stall_episode();
    set_config(15'd32767, 16'd0, 16'd32768, 16'd32768, 16'd32768);
    repeat (3) stall_episode();
    set_config(CMD_FLOOR_RST, DETECT_MS_RST, CMD_TRIGGER_RST, SPEED_TRIGGER_RST,
               CURRENT_TRIGGER_RST);
    repeat (3) stall_episode();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    logic [14:0] fl;
    for (int ph = 0; ph < 8; ph++) begin
      fl = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 1) * 32767)
                                       : 15'($urandom_range(0, 2000));
      set_config(fl, pick_threshold(300), pick_threshold(3000), pick_threshold(200),
                 pick_threshold(3000));
      phase_end = sent_count + 150;
      while (sent_count < phase_end) begin
        src_calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 8) begin
          stall_episode();
        end else begin
          repeat ($urandom_range(1, 5)) send_update(noise_update());
        end
        // drift toward the 32 bit wrap now and then
        if ($urandom_range(0, 6) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
      end
    end
    src_calm = 1'b0;
  endtask

  // receiver pacing: mostly ready, short and long stalls, calm stretches
  initial begin : sink_pacing
    int unsigned busy;
    int unsigned r;
    int unsigned calm_left;
    calm_left = 0;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 299);
      busy = 0;
      if (calm_left > 0) begin
        calm_left--;
      end else if (r == 0) begin
        calm_left = $urandom_range(50, 200);
      end else if (r >= 210 && r < 280) begin
        busy = $urandom_range(1, 3);
      end else if (r >= 280) begin
        busy = $urandom_range(8, 30);
      end
      if (busy > 0) begin
        m_axis_tready <= 1'b0;
        repeat (busy) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : drive_check
    drive_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected result: expected none, got 0x%h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_drive.pop_front();
        check_field("drive_left", int'(want.drv_l), int'($signed(m_axis_tdata[15:0])));
        check_field("drive_right", int'(want.drv_r), int'($signed(m_axis_tdata[31:16])));
        check_field("drive_enable", int'(want.enable), int'(m_axis_tdata[32]));
        check_field("supervisor_active", int'(want.active), int'(m_axis_tdata[33]));
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("motor_stall_supervisor_top_test: errors");
    $finish;
  end

  initial begin : run_all
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough_extremes();
    test_detect_armed_at_zero();
    test_ramp_hold_release();
    test_stamp_wrap();
    test_config_extremes();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("motor_stall_supervisor_top_test: clean");
    end else begin
      $display("motor_stall_supervisor_top_test: errors");
    end
    $finish;
  end

endmodule
